### hw/rtl/sbf_pkg.sv
// sbf_pkg: constants, register indexes and shared types of the serial bus frame decoder.
// Used by the interfaces and by every module of the block; depends on nothing.
`default_nettype none

package sbf_pkg;

    localparam int CHANNELS    = 16;
    localparam int FRAME_BYTES = 25;
    localparam int BODY_BYTES  = FRAME_BYTES - 2;
    localparam int COUNT_WIDTH = 32;

    localparam int BYTE_W   = 8;
    localparam int BODY_W   = BODY_BYTES * BYTE_W;
    localparam int RAW_W    = 11;
    localparam int CH_W     = 4;
    localparam int POS_W    = 5;
    localparam int SCALED_W = 16;
    localparam int Q_FRAC   = 14;
    localparam int Q_ONE    = 1 << Q_FRAC;
    localparam int QUO_W    = Q_FRAC + 1;
    localparam int REM_W    = RAW_W + 1;
    localparam int STEP_W   = $clog2(QUO_W);
    localparam int DIFF_W   = RAW_W + 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = RAW_W;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VALUE = CFG_IDX_W'(1);

    localparam logic [RAW_W-1:0]  MAX_RESET  = RAW_W'(2000);
    localparam logic [RAW_W-1:0]  MIN_RESET  = RAW_W'(1000);
    localparam logic [BYTE_W-1:0] START_BYTE = 8'h0F;
    localparam logic [BYTE_W-1:0] END_BYTE   = 8'h00;

    localparam int FLAG_D17  = 0;
    localparam int FLAG_D18  = 1;
    localparam int FLAG_FAIL = 3;

    typedef struct packed {
        logic fire;
        logic ok;
    } t_frame_ev;

endpackage

`default_nettype wire

### hw/rtl/sbf_if.sv
// sbf_if: valid/ready channels of the frame decoder: received bytes, config writes, results.
// Depends on sbf_pkg for field widths.
`default_nettype none

interface sbf_byte_if import sbf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sbf_cfg_if import sbf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] reg_data;

    modport source (output valid, output reg_index, output reg_data, input ready);
    modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

interface sbf_res_if import sbf_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [CH_W-1:0]            channel_index;
    logic [RAW_W-1:0]           raw_value;
    logic signed [SCALED_W-1:0] scaled_value;
    logic                       in_range;
    logic                       digital_17;
    logic                       digital_18;
    logic                       failsafe_flag;
    logic                       frame_ok;
    logic [COUNT_WIDTH-1:0]     good_frames;
    logic [COUNT_WIDTH-1:0]     bad_frames;
    logic                       last_of_run;

    modport source (
        output valid, output channel_index, output raw_value, output scaled_value,
        output in_range, output digital_17, output digital_18, output failsafe_flag,
        output frame_ok, output good_frames, output bad_frames, output last_of_run,
        input ready
    );
    modport sink (
        input valid, input channel_index, input raw_value, input scaled_value,
        input in_range, input digital_17, input digital_18, input failsafe_flag,
        input frame_ok, input good_frames, input bad_frames, input last_of_run,
        output ready
    );
endinterface

`default_nettype wire

### hw/rtl/sbus_frame_decoder.sv
// sbus_frame_decoder: top level of the serial bus frame decoder, with the config registers.
// Instantiates sbf_framer and sbf_chan; depends on sbf_pkg and sbf_if.
//
//  channel  dir  word contents
//  i_rx     in   rx_byte: one received serial byte
//  i_cfg    in   reg_index, reg_data: 0 max_value, 1 min_value, others ignored
//  o_res    out  one channel result, or one error result on a bad end byte
//
// A byte is taken while input ready is high; the 24th byte after a start byte ends the frame.
// A good frame then gives 16 results; an in-range channel with a nonzero divisor goes
// through LOAD, 15 divider steps, FIN and output; any other channel skips the divider.
// An error result follows its byte through the frame event and state registers.
// Input ready stays low while results are produced or wait on a stalled sink.
// Reset clears counters, position and registers to 2000/1000; the body is not cleared.
`default_nettype none

module sbus_frame_decoder import sbf_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sbf_byte_if.sink  i_rx,
    sbf_cfg_if.sink   i_cfg,
    sbf_res_if.source o_res
);

    logic [RAW_W-1:0]       r_max;
    logic [RAW_W-1:0]       r_min;
    t_frame_ev              ev;
    logic [RAW_W-1:0]       raw;
    logic [BYTE_W-1:0]      flags;
    logic [COUNT_WIDTH-1:0] good;
    logic [COUNT_WIDTH-1:0] bad;
    logic                   busy;
    logic                   adv;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_RESET;
            r_min <= MIN_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                REG_MAX_VALUE: r_max <= i_cfg.reg_data;
                REG_MIN_VALUE: r_min <= i_cfg.reg_data;
                default: ;
            endcase
        end
    end

    sbf_framer u_framer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_busy  (busy),
        .i_adv   (adv),
        .o_ev    (ev),
        .o_raw   (raw),
        .o_flags (flags),
        .o_good  (good),
        .o_bad   (bad)
    );

    sbf_chan u_chan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ev    (ev),
        .i_raw   (raw),
        .i_flags (flags),
        .i_good  (good),
        .i_bad   (bad),
        .i_max   (r_max),
        .i_min   (r_min),
        .o_busy  (busy),
        .o_adv   (adv),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

### hw/rtl/sbf_div.sv
// sbf_div: bit-serial restoring divider, one quotient bit per cycle, Q_FRAC fraction bits.
// Computes floor(num * 2^Q_FRAC / den) for num <= den. Depends on sbf_pkg.
`default_nettype none

module sbf_div import sbf_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [REM_W-1:0] i_num,
    input  wire logic [RAW_W-1:0] i_den,
    output logic                  o_done,
    output logic [QUO_W-1:0]      o_quo
);

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic [REM_W-1:0]  r_rem;
    logic [QUO_W-1:0]  r_q;
    logic [RAW_W-1:0]  r_den;
    logic              ge;
    logic [REM_W-1:0]  rem_sub;

    assign ge      = r_rem >= {1'b0, r_den};
    assign rem_sub = ge ? (r_rem - {1'b0, r_den}) : r_rem;
    assign o_done  = r_busy && (r_step == '0);
    assign o_quo   = {r_q[QUO_W-2:0], ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= STEP_W'(QUO_W - 1);
        end else if (r_busy) begin
            r_step <= r_step - 1'b1;
            if (r_step == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= {rem_sub[REM_W-2:0], 1'b0};
            r_q   <= {r_q[QUO_W-2:0], ge};
        end
    end

endmodule

`default_nettype wire

### hw/rtl/sbf_framer.sv
// sbf_framer: start-byte hunt, body shift register, end-byte check and frame counters.
// Shifts the body out RAW_W bits at a time on request. Depends on sbf_pkg, sbf_if.
`default_nettype none

module sbf_framer import sbf_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    sbf_byte_if.sink           i_rx,
    input  wire logic          i_busy,
    input  wire logic          i_adv,
    output t_frame_ev          o_ev,
    output logic [RAW_W-1:0]   o_raw,
    output logic [BYTE_W-1:0]  o_flags,
    output logic [COUNT_WIDTH-1:0] o_good,
    output logic [COUNT_WIDTH-1:0] o_bad
);

    localparam logic [POS_W-1:0] POS_END = POS_W'(BODY_BYTES + 1);

    logic [POS_W-1:0]       r_pos;
    logic [BODY_W-1:0]      r_body;
    logic [COUNT_WIDTH-1:0] r_good;
    logic [COUNT_WIDTH-1:0] r_bad;
    t_frame_ev              r_ev;
    logic                   accept;

    assign i_rx.ready = !i_busy && !r_ev.fire;
    assign accept     = i_rx.valid && i_rx.ready;
    assign o_ev       = r_ev;
    assign o_raw      = r_body[RAW_W-1:0];
    assign o_flags    = r_body[BODY_W-1 -: BYTE_W];
    assign o_good     = r_good;
    assign o_bad      = r_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_good <= '0;
            r_bad  <= '0;
            r_ev   <= '0;
        end else begin
            r_ev <= '0;
            if (accept) begin
                if (r_pos == '0) begin
                    if (i_rx.rx_byte == START_BYTE) begin
                        r_pos <= POS_W'(1);
                    end
                end else if (r_pos == POS_END) begin
                    r_pos      <= '0;
                    r_ev.fire  <= 1'b1;
                    if (i_rx.rx_byte == END_BYTE) begin
                        r_ev.ok <= 1'b1;
                        r_good  <= r_good + 1'b1;
                    end else begin
                        r_bad <= r_bad + 1'b1;
                    end
                end else begin
                    r_pos <= r_pos + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (r_pos != '0) && (r_pos != POS_END)) begin
            r_body <= {i_rx.rx_byte, r_body[BODY_W-1:BYTE_W]};
        end else if (i_adv) begin
            r_body <= {{RAW_W{1'b0}}, r_body[BODY_W-1:RAW_W]};
        end
    end

endmodule

`default_nettype wire

### hw/rtl/sbf_chan.sv
// sbf_chan: per-channel sequencer: range check, Q1.14 scaling through sbf_div, result register.
// Depends on sbf_pkg, sbf_if and sbf_div.
`default_nettype none

module sbf_chan import sbf_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_frame_ev         i_ev,
    input  wire logic [RAW_W-1:0]  i_raw,
    input  wire logic [BYTE_W-1:0] i_flags,
    input  wire logic [COUNT_WIDTH-1:0] i_good,
    input  wire logic [COUNT_WIDTH-1:0] i_bad,
    input  wire logic [RAW_W-1:0]  i_max,
    input  wire logic [RAW_W-1:0]  i_min,
    output logic                   o_busy,
    output logic                   o_adv,
    sbf_res_if.source              o_res
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,
        S_DIV  = 5'b00100,
        S_FIN  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state                     r_state;
    t_state                     n_state;
    logic [CH_W-1:0]            r_ch;
    logic [RAW_W-1:0]           r_mid;
    logic [RAW_W-1:0]           r_div;
    logic [RAW_W-1:0]           r_raw;
    logic                       r_inr;
    logic                       r_neg;
    logic                       r_ok;
    logic [BYTE_W-1:0]          r_flags;
    logic [QUO_W-1:0]           r_quo;
    logic signed [SCALED_W-1:0] r_scaled;

    logic [RAW_W:0]    sum;
    logic              in_rng;
    logic [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0] mag;
    logic              skip;
    logic              div_start;
    logic              div_done;
    logic [QUO_W-1:0]  div_quo;
    logic              last;

    assign sum       = {1'b0, i_max} + {1'b0, i_min};
    assign in_rng    = (i_raw >= i_min) && (i_raw <= i_max);
    assign diff      = {2'b00, i_raw} - {2'b00, r_mid};
    assign mag       = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
    assign skip      = !in_rng || (r_div == '0);
    assign div_start = (r_state == S_LOAD) && !skip;
    assign last      = r_ch == CH_W'(CHANNELS - 1);

    assign o_busy = r_state != S_IDLE;
    assign o_adv  = r_state == S_LOAD;

    sbf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (mag[REM_W-1:0]),
        .i_den   (r_div),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_ev.fire) begin
                    n_state = i_ev.ok ? S_LOAD : S_OUT;
                end
            end
            S_LOAD: n_state = skip ? S_FIN : S_DIV;
            S_DIV: begin
                if (div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: n_state = S_OUT;
            S_OUT: begin
                if (o_res.ready) begin
                    n_state = (!r_ok || last) ? S_IDLE : S_LOAD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ch    <= '0;
            r_ok    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && i_ev.fire) begin
                r_ch <= '0;
                r_ok <= i_ev.ok;
            end else if (r_state == S_OUT && o_res.ready) begin
                r_ch <= r_ch + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_ev.fire) begin
                    r_mid    <= sum[RAW_W:1];
                    r_div    <= i_max - sum[RAW_W:1];
                    r_flags  <= i_ev.ok ? i_flags : '0;
                    r_raw    <= '0;
                    r_inr    <= 1'b0;
                    r_scaled <= '0;
                end
            end
            S_LOAD: begin
                r_raw <= i_raw;
                r_inr <= in_rng;
                r_neg <= diff[DIFF_W-1];
                r_quo <= '0;
            end
            S_DIV: begin
                if (div_done) begin
                    r_quo <= div_quo;
                end
            end
            S_FIN: begin
                r_scaled <= r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
            end
            S_OUT: ;
            default: ;
        endcase
    end

    assign o_res.valid         = r_state == S_OUT;
    assign o_res.channel_index = r_ch;
    assign o_res.raw_value     = r_raw;
    assign o_res.scaled_value  = r_scaled;
    assign o_res.in_range      = r_inr;
    assign o_res.digital_17    = r_flags[FLAG_D17];
    assign o_res.digital_18    = r_flags[FLAG_D18];
    assign o_res.failsafe_flag = r_flags[FLAG_FAIL];
    assign o_res.frame_ok      = r_ok;
    assign o_res.good_frames   = i_good;
    assign o_res.bad_frames    = i_bad;
    assign o_res.last_of_run   = !r_ok || last;

endmodule

`default_nettype wire

### hw/rtl/sbf_check.sv
// sbf_check: port-level assertions for sbus_frame_decoder, attached by bind.
// Depends on sbf_pkg; sees only the top level's ports.
`default_nettype none

module sbf_check import sbf_pkg::*; (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_rx_ready,
    input wire logic                       i_res_valid,
    input wire logic                       i_res_ready,
    input wire logic [CH_W-1:0]            i_res_ch,
    input wire logic [RAW_W-1:0]           i_res_raw,
    input wire logic signed [SCALED_W-1:0] i_res_scaled,
    input wire logic                       i_res_inr,
    input wire logic                       i_res_ok,
    input wire logic                       i_res_last
);

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_ch)
            && $stable(i_res_raw) && $stable(i_res_scaled))
        else $error("result word changed under stall");

    a_no_rx_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> !i_rx_ready)
        else $error("byte input open while a result is pending");

    a_error_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ok |-> i_res_last && (i_res_ch == '0) && (i_res_raw == '0)
            && (i_res_scaled == '0) && !i_res_inr)
        else $error("malformed error result");

    a_scaled_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res_inr || (i_res_scaled == '0))
            && (i_res_scaled <= Q_ONE) && (i_res_scaled >= -Q_ONE))
        else $error("scaled value out of bounds");

endmodule

bind sbus_frame_decoder sbf_check u_sbf_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_rx_ready   (i_rx.ready),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_ch     (o_res.channel_index),
    .i_res_raw    (o_res.raw_value),
    .i_res_scaled (o_res.scaled_value),
    .i_res_inr    (o_res.in_range),
    .i_res_ok     (o_res.frame_ok),
    .i_res_last   (o_res.last_of_run)
);

`default_nettype wire
